FILE: rtl/fbc_pkg.sv
package fbc_pkg;

	localparam int COORD_W      = 16;
	localparam int PLANE_W      = 64;
	localparam int OFFSET_SHIFT = 14;
	localparam int PROD_W       = 2 * COORD_W;
	localparam int PART_W       = PROD_W + 1;
	localparam int SUM_W        = PROD_W + 2;
	localparam int REG_LSB      = 3;
	localparam int VERDICT_W    = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] nz;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_min;
		logic signed [COORD_W-1:0] x_max;
		logic signed [COORD_W-1:0] y_min;
		logic signed [COORD_W-1:0] y_max;
		logic signed [COORD_W-1:0] z_min;
		logic signed [COORD_W-1:0] z_max;
	} box_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_INSIDE    = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_OUTSIDE   = 2'd2
	} verdict_t;

endpackage

FILE: rtl/fbc_cfg.sv
module fbc_cfg #(
	parameter int PLANE_COUNT = 6,
	parameter int ADDR_W      = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [fbc_pkg::PLANE_W-1:0] pwdata,
	output logic [fbc_pkg::PLANE_W-1:0] prdata,
	output fbc_pkg::plane_t         planes [PLANE_COUNT]
);
	import fbc_pkg::*;

	localparam int IDX_W = ADDR_W - REG_LSB;

	logic [IDX_W-1:0] idx;
	logic             wr;
	plane_t           planes_q [PLANE_COUNT];

	assign idx = paddr[ADDR_W-1:REG_LSB];
	assign wr  = psel && penable && pwrite;

	// indexes past the last plane decode to nothing
	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				planes_q[g] <= '0;
			end else if (wr && idx == IDX_W'(g)) begin
				planes_q[g] <= plane_t'(pwdata);
			end
		end
		assign planes[g] = planes_q[g];
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			if (idx == IDX_W'(i)) begin
				prdata = PLANE_W'(planes_q[i]);
			end
		end
	end

endmodule

FILE: rtl/fbc_lane.sv
module fbc_lane (
	input  logic                clk,
	input  fbc_pkg::plane_t     plane,
	input  fbc_pkg::box_t       box,
	input  fbc_pkg::stage_en_t  en,
	output logic                far_neg_s3,
	output logic                near_neg_s3
);
	import fbc_pkg::*;

	logic signed [COORD_W-1:0] far_x, far_y, far_z;
	logic signed [COORD_W-1:0] near_x, near_y, near_z;
	logic signed [PROD_W-1:0]  far_px_s1, far_py_s1, far_pz_s1;
	logic signed [PROD_W-1:0]  near_px_s1, near_py_s1, near_pz_s1;
	logic signed [PART_W-1:0]  offset_scaled;
	logic signed [PART_W-1:0]  far_a_s2, far_b_s2, near_a_s2, near_b_s2;
	logic signed [SUM_W-1:0]   far_sum, near_sum;

	// positive normal component: far corner on the max bound, zero counts as not positive
	always_comb begin
		if (plane.nx > 0) begin
			far_x  = box.x_max;
			near_x = box.x_min;
		end else begin
			far_x  = box.x_min;
			near_x = box.x_max;
		end
		if (plane.ny > 0) begin
			far_y  = box.y_max;
			near_y = box.y_min;
		end else begin
			far_y  = box.y_min;
			near_y = box.y_max;
		end
		if (plane.nz > 0) begin
			far_z  = box.z_max;
			near_z = box.z_min;
		end else begin
			far_z  = box.z_min;
			near_z = box.z_max;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			far_px_s1  <= plane.nx * far_x;
			far_py_s1  <= plane.ny * far_y;
			far_pz_s1  <= plane.nz * far_z;
			near_px_s1 <= plane.nx * near_x;
			near_py_s1 <= plane.ny * near_y;
			near_pz_s1 <= plane.nz * near_z;
		end
	end

	// offset brought from Q12.4 to the Q.18 scale of the products
	assign offset_scaled = PART_W'(plane.d) <<< OFFSET_SHIFT;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			far_a_s2  <= PART_W'(far_px_s1) + PART_W'(far_py_s1);
			far_b_s2  <= PART_W'(far_pz_s1) + offset_scaled;
			near_a_s2 <= PART_W'(near_px_s1) + PART_W'(near_py_s1);
			near_b_s2 <= PART_W'(near_pz_s1) + offset_scaled;
		end
	end

	assign far_sum  = SUM_W'(far_a_s2) + SUM_W'(far_b_s2);
	assign near_sum = SUM_W'(near_a_s2) + SUM_W'(near_b_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			far_neg_s3  <= far_sum[SUM_W-1];
			near_neg_s3 <= near_sum[SUM_W-1];
		end
	end

endmodule

FILE: rtl/fbc_ctrl.sv
module fbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               box_valid,
	output logic               box_stall,
	output logic               verdict_valid,
	input  logic               verdict_stall,
	output fbc_pkg::stage_en_t en
);
	import fbc_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready1, ready2, ready3, ready4;

	// a stage loads when it is empty or its content moves on, so bubbles close up
	assign ready4 = !valid_s4 || !verdict_stall;
	assign ready3 = !valid_s3 || ready4;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;

	assign en.s1 = ready1;
	assign en.s2 = ready2;
	assign en.s3 = ready3;
	assign en.s4 = ready4;

	assign box_stall     = !ready1;
	assign verdict_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= box_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && !box_stall) |=> valid_s1)
		else $error("accepted item did not reach stage 1");

	a_s3_moves_to_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en.s4) |=> valid_s4)
		else $error("item lost between stage 3 and stage 4");

	a_empty_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !box_stall)
		else $error("input stalled with stage 1 empty");

	a_full_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && verdict_stall) |-> box_stall)
		else $error("full pipeline took an item under output stall");

endmodule

FILE: rtl/frustum_box_cull_top.sv
// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------------
// box in    | box_valid / box_stall        | x_min x_max y_min y_max z_min z_max
// verdict   | verdict_valid / verdict_stall| verdict (0 inside, 1 intersect, 2 out)
// config    | apb psel penable pwrite      | plane i at byte 8*i, 64-bit data
//
// one box per cycle unless a verdict stall backs up; stages: products, partial sums, plane signs, verdict
// the four register stages each hold one box, one lane per plane works in parallel
// arst_n clears the stage valid bits and all planes (every box then reads inside)
// a stall on the verdict side backs up through full stages only, empty ones still fill
module frustum_box_cull_top #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [((PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1) + fbc_pkg::REG_LSB - 1:0] paddr,
	input  logic [fbc_pkg::PLANE_W-1:0]   pwdata,
	output logic [fbc_pkg::PLANE_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          box_valid,
	output logic                          box_stall,
	input  logic signed [fbc_pkg::COORD_W-1:0] x_min,
	input  logic signed [fbc_pkg::COORD_W-1:0] x_max,
	input  logic signed [fbc_pkg::COORD_W-1:0] y_min,
	input  logic signed [fbc_pkg::COORD_W-1:0] y_max,
	input  logic signed [fbc_pkg::COORD_W-1:0] z_min,
	input  logic signed [fbc_pkg::COORD_W-1:0] z_max,
	output logic                          verdict_valid,
	input  logic                          verdict_stall,
	output logic [fbc_pkg::VERDICT_W-1:0] verdict
);
	import fbc_pkg::*;

	localparam int IDX_W  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
	localparam int ADDR_W = IDX_W + REG_LSB;

	plane_t                 planes [PLANE_COUNT];
	box_t                   box;
	stage_en_t              en;
	logic [PLANE_COUNT-1:0] far_neg_s3;
	logic [PLANE_COUNT-1:0] near_neg_s3;
	verdict_t               verdict_s4;
	verdict_t               verdict_next;

	assign pready = 1'b1;

	fbc_cfg #(
		.PLANE_COUNT (PLANE_COUNT),
		.ADDR_W      (ADDR_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.planes  (planes)
	);

	fbc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.box_valid     (box_valid),
		.box_stall     (box_stall),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.en            (en)
	);

	assign box.x_min = x_min;
	assign box.x_max = x_max;
	assign box.y_min = y_min;
	assign box.y_max = y_max;
	assign box.z_min = z_min;
	assign box.z_max = z_max;

	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
		fbc_lane u_lane (
			.clk         (clk),
			.plane       (planes[g]),
			.box         (box),
			.en          (en),
			.far_neg_s3  (far_neg_s3[g]),
			.near_neg_s3 (near_neg_s3[g])
		);
	end

	// far corner behind any plane wins over any near corner result
	always_comb begin
		if (|far_neg_s3) begin
			verdict_next = VERDICT_OUTSIDE;
		end else if (|near_neg_s3) begin
			verdict_next = VERDICT_INTERSECT;
		end else begin
			verdict_next = VERDICT_INSIDE;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			verdict_s4 <= verdict_next;
		end
	end

	assign verdict = verdict_s4;

endmodule
